@@ rtl/i2cra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: shared types and constants
// Payload structs, configuration struct, phase and command codes.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  localparam int PhaseW = 5;

  // sequencer phase codes
  localparam logic [PhaseW-1:0] PH_IDLE     = 5'd0;
  localparam logic [PhaseW-1:0] PH_START_A  = 5'd1;
  localparam logic [PhaseW-1:0] PH_START_B  = 5'd2;
  localparam logic [PhaseW-1:0] PH_TX_LOW   = 5'd3;
  localparam logic [PhaseW-1:0] PH_TX_HIGH  = 5'd4;
  localparam logic [PhaseW-1:0] PH_ACK_LOW  = 5'd5;
  localparam logic [PhaseW-1:0] PH_ACK_HIGH = 5'd6;
  localparam logic [PhaseW-1:0] PH_RS_A     = 5'd7;
  localparam logic [PhaseW-1:0] PH_RS_B     = 5'd8;
  localparam logic [PhaseW-1:0] PH_RS_C     = 5'd9;
  localparam logic [PhaseW-1:0] PH_RX_LOW   = 5'd10;
  localparam logic [PhaseW-1:0] PH_RX_HIGH  = 5'd11;
  localparam logic [PhaseW-1:0] PH_MA_LOW   = 5'd12;
  localparam logic [PhaseW-1:0] PH_MA_HIGH  = 5'd13;
  localparam logic [PhaseW-1:0] PH_STOP_A   = 5'd14;
  localparam logic [PhaseW-1:0] PH_STOP_B   = 5'd15;
  localparam logic [PhaseW-1:0] PH_STOP_C   = 5'd16;
  localparam logic [PhaseW-1:0] PH_ESTOP_A  = 5'd17;
  localparam logic [PhaseW-1:0] PH_ESTOP_B  = 5'd18;
  localparam logic [PhaseW-1:0] PH_ESTOP_C  = 5'd19;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // byte steps of a transaction
  localparam logic [2:0] STEP_ADDR  = 3'd0;
  localparam logic [2:0] STEP_REG   = 3'd1;
  localparam logic [2:0] STEP_THIRD = 3'd2;
  localparam logic [2:0] STEP_FOURTH = 3'd3;
  localparam logic [2:0] STEP_LAST  = 3'd4;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;

  localparam logic [6:0] ADDRESS_RESET = 7'd42;
  localparam logic [7:0] TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [15:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ack_timeout;
  } cfg_regs_t;

endpackage

@@ rtl/i2cra_seq.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: bus sequencer
// Runs one half-bit tick per enabled cycle: updates the phase state and
// forms the bus levels and status word for that tick.
// ----------------------------------------------------------------------------
module i2cra_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  i2cra_pkg::in_item_t   item,
  input  i2cra_pkg::cfg_regs_t  cfg,
  output i2cra_pkg::out_item_t  res
);

  logic [i2cra_pkg::PhaseW-1:0] phase_r, phase_nxt, phase_c;
  logic [2:0]  bit_count_r, bit_count_nxt, bit_count_c;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [2:0]  byte_step_r, byte_step_nxt, byte_step_c;
  logic [7:0]  wait_count_r, wait_count_nxt, wait_count_c;
  logic [7:0]  held_reg_r, held_reg_nxt, held_reg_c;
  logic [15:0] held_data_r, held_data_nxt, held_data_c;
  logic        is_read_r, is_read_nxt, is_read_c;
  logic [15:0] read_buf_r, read_buf_nxt, read_buf_c;
  logic        start;
  logic [7:0]  rx_byte;

  function automatic logic [7:0] byte_for_step(
    input logic [2:0]  step,
    input logic [6:0]  dev,
    input logic [7:0]  regb,
    input logic [15:0] data,
    input logic        rd
  );
    logic [7:0] b;
    b = 8'h00;
    unique case (step)
      i2cra_pkg::STEP_ADDR:  b = {dev, 1'b0};
      i2cra_pkg::STEP_REG:   b = regb;
      i2cra_pkg::STEP_THIRD: b = rd ? {dev, 1'b1} : data[15:8];
      default:               b = data[7:0];
    endcase
    return b;
  endfunction

  assign start = (phase_r == i2cra_pkg::PH_IDLE) &&
                 ((item.cmd == i2cra_pkg::CMD_WRITE) || (item.cmd == i2cra_pkg::CMD_READ));
  assign rx_byte = {shift_byte_r[6:0], item.sda_in};

  always_comb begin
    // a command in idle is latched and its first start tick runs at once
    phase_c      = start ? i2cra_pkg::PH_START_A : phase_r;
    held_reg_c   = start ? item.reg_addr : held_reg_r;
    held_data_c  = start ? item.write_data : held_data_r;
    is_read_c    = start ? (item.cmd == i2cra_pkg::CMD_READ) : is_read_r;
    read_buf_c   = start ? 16'h0000 : read_buf_r;
    byte_step_c  = start ? i2cra_pkg::STEP_ADDR : byte_step_r;
    bit_count_c  = start ? 3'd0 : bit_count_r;
    wait_count_c = start ? 8'd0 : wait_count_r;

    phase_nxt      = phase_c;
    held_reg_nxt   = held_reg_c;
    held_data_nxt  = held_data_c;
    is_read_nxt    = is_read_c;
    read_buf_nxt   = read_buf_c;
    byte_step_nxt  = byte_step_c;
    bit_count_nxt  = bit_count_c;
    wait_count_nxt = wait_count_c;
    shift_byte_nxt = shift_byte_r;

    res = '0;
    res.scl      = 1'b1;
    res.busy_res = 1'b1;

    unique case (phase_c)
      i2cra_pkg::PH_START_A: begin
        phase_nxt = i2cra_pkg::PH_START_B;
      end
      i2cra_pkg::PH_START_B: begin
        res.sda_pull_low = 1'b1;
        byte_step_nxt  = i2cra_pkg::STEP_ADDR;
        shift_byte_nxt = byte_for_step(i2cra_pkg::STEP_ADDR, cfg.device_address,
                                       held_reg_c, held_data_c, is_read_c);
        bit_count_nxt  = 3'd0;
        phase_nxt      = i2cra_pkg::PH_TX_LOW;
      end
      i2cra_pkg::PH_TX_LOW: begin
        res.scl          = 1'b0;
        res.sda_pull_low = ~shift_byte_r[7];
        phase_nxt        = i2cra_pkg::PH_TX_HIGH;
      end
      i2cra_pkg::PH_TX_HIGH: begin
        res.sda_pull_low = ~shift_byte_r[7];
        shift_byte_nxt   = {shift_byte_r[6:0], 1'b0};
        if (bit_count_c == i2cra_pkg::LAST_BIT) begin
          phase_nxt = i2cra_pkg::PH_ACK_LOW;
        end else begin
          bit_count_nxt = bit_count_c + 3'd1;
          phase_nxt     = i2cra_pkg::PH_TX_LOW;
        end
      end
      i2cra_pkg::PH_ACK_LOW: begin
        res.scl        = 1'b0;
        wait_count_nxt = 8'd0;
        phase_nxt      = i2cra_pkg::PH_ACK_HIGH;
      end
      i2cra_pkg::PH_ACK_HIGH: begin
        if (!item.sda_in) begin
          if (is_read_c && byte_step_c == i2cra_pkg::STEP_REG) begin
            byte_step_nxt = i2cra_pkg::STEP_THIRD;
            phase_nxt     = i2cra_pkg::PH_RS_A;
          end else if (is_read_c && byte_step_c != i2cra_pkg::STEP_ADDR) begin
            byte_step_nxt  = i2cra_pkg::STEP_FOURTH;
            bit_count_nxt  = 3'd0;
            shift_byte_nxt = 8'h00;
            phase_nxt      = i2cra_pkg::PH_RX_LOW;
          end else if (!is_read_c && byte_step_c >= i2cra_pkg::STEP_FOURTH) begin
            phase_nxt = i2cra_pkg::PH_STOP_A;
          end else begin
            // load the next byte to send
            byte_step_nxt  = byte_step_c + 3'd1;
            shift_byte_nxt = byte_for_step(byte_step_c + 3'd1, cfg.device_address,
                                           held_reg_c, held_data_c, is_read_c);
            bit_count_nxt  = 3'd0;
            phase_nxt      = i2cra_pkg::PH_TX_LOW;
          end
        end else if (wait_count_c >= cfg.ack_timeout) begin
          phase_nxt = i2cra_pkg::PH_ESTOP_A;
        end else begin
          wait_count_nxt = wait_count_c + 8'd1;
        end
      end
      i2cra_pkg::PH_RS_A: begin
        res.scl   = 1'b0;
        phase_nxt = i2cra_pkg::PH_RS_B;
      end
      i2cra_pkg::PH_RS_B: begin
        phase_nxt = i2cra_pkg::PH_RS_C;
      end
      i2cra_pkg::PH_RS_C: begin
        res.sda_pull_low = 1'b1;
        byte_step_nxt  = i2cra_pkg::STEP_THIRD;
        shift_byte_nxt = byte_for_step(i2cra_pkg::STEP_THIRD, cfg.device_address,
                                       held_reg_c, held_data_c, is_read_c);
        bit_count_nxt  = 3'd0;
        phase_nxt      = i2cra_pkg::PH_TX_LOW;
      end
      i2cra_pkg::PH_RX_LOW: begin
        res.scl   = 1'b0;
        phase_nxt = i2cra_pkg::PH_RX_HIGH;
      end
      i2cra_pkg::PH_RX_HIGH: begin
        shift_byte_nxt = rx_byte;
        if (bit_count_c == i2cra_pkg::LAST_BIT) begin
          read_buf_nxt = {read_buf_c[7:0], rx_byte};
          phase_nxt    = i2cra_pkg::PH_MA_LOW;
        end else begin
          bit_count_nxt = bit_count_c + 3'd1;
          phase_nxt     = i2cra_pkg::PH_RX_LOW;
        end
      end
      i2cra_pkg::PH_MA_LOW: begin
        res.scl          = 1'b0;
        res.sda_pull_low = (byte_step_c == i2cra_pkg::STEP_FOURTH);
        phase_nxt        = i2cra_pkg::PH_MA_HIGH;
      end
      i2cra_pkg::PH_MA_HIGH: begin
        res.sda_pull_low = (byte_step_c == i2cra_pkg::STEP_FOURTH);
        if (byte_step_c == i2cra_pkg::STEP_FOURTH) begin
          byte_step_nxt  = i2cra_pkg::STEP_LAST;
          bit_count_nxt  = 3'd0;
          shift_byte_nxt = 8'h00;
          phase_nxt      = i2cra_pkg::PH_RX_LOW;
        end else begin
          phase_nxt = i2cra_pkg::PH_STOP_A;
        end
      end
      i2cra_pkg::PH_STOP_A: begin
        res.scl          = 1'b0;
        res.sda_pull_low = 1'b1;
        phase_nxt        = i2cra_pkg::PH_STOP_B;
      end
      i2cra_pkg::PH_ESTOP_A: begin
        res.scl          = 1'b0;
        res.sda_pull_low = 1'b1;
        phase_nxt        = i2cra_pkg::PH_ESTOP_B;
      end
      i2cra_pkg::PH_STOP_B: begin
        res.sda_pull_low = 1'b1;
        phase_nxt        = i2cra_pkg::PH_STOP_C;
      end
      i2cra_pkg::PH_ESTOP_B: begin
        res.sda_pull_low = 1'b1;
        phase_nxt        = i2cra_pkg::PH_ESTOP_C;
      end
      i2cra_pkg::PH_STOP_C: begin
        res.done_res  = 1'b1;
        res.read_data = is_read_c ? read_buf_c : 16'h0000;
        phase_nxt     = i2cra_pkg::PH_IDLE;
      end
      i2cra_pkg::PH_ESTOP_C: begin
        res.done_res  = 1'b1;
        res.ack_error = 1'b1;
        phase_nxt     = i2cra_pkg::PH_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = i2cra_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cra_pkg::PH_IDLE;
      bit_count_r  <= 3'd0;
      shift_byte_r <= 8'h00;
      byte_step_r  <= 3'd0;
      wait_count_r <= 8'd0;
      held_reg_r   <= 8'h00;
      held_data_r  <= 16'h0000;
      is_read_r    <= 1'b0;
      read_buf_r   <= 16'h0000;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_byte_r <= shift_byte_nxt;
      byte_step_r  <= byte_step_nxt;
      wait_count_r <= wait_count_nxt;
      held_reg_r   <= held_reg_nxt;
      held_data_r  <= held_data_nxt;
      is_read_r    <= is_read_nxt;
      read_buf_r   <= read_buf_nxt;
    end
  end

endmodule

@@ rtl/i2c_register_access_master_core.sv @@
// ----------------------------------------------------------------------------
// I2C register access master core
// Data path: a word accepted into the input register passes through the
// sequencer into the result register, which drives out_data.
// Throughput: one word per cycle while the result is not stalled; the input
// register and the result register part the two channels, so a stalled
// result still lets one word in. Reset: synchronous, active low; sequencer
// idle, device_address 42, ack_timeout 250. The configuration port is always ready.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cra_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cra_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  i2cra_pkg::in_item_t  in_item_r;
  logic                 in_valid_r;
  i2cra_pkg::out_item_t out_item_r;
  logic                 out_valid_r;
  i2cra_pkg::cfg_regs_t cfg_r;
  i2cra_pkg::out_item_t step_res;
  logic                 out_load;
  logic                 step_en;

  assign out_load  = !out_valid_r || out_ready;
  assign step_en   = in_valid_r && out_load;
  assign in_ready  = !in_valid_r || step_en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= i2cra_pkg::ADDRESS_RESET;
      cfg_r.ack_timeout    <= i2cra_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      // drop writes beyond the register list
      if (cfg_index == i2cra_pkg::CFG_DEVICE_ADDRESS) begin
        cfg_r.device_address <= cfg_data[6:0];
      end else if (cfg_index == i2cra_pkg::CFG_ACK_TIMEOUT) begin
        cfg_r.ack_timeout <= cfg_data;
      end
    end
  end

  i2cra_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.done_res |-> out_item_r.busy_res)
    else $error("done word without busy");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.ack_error |-> out_item_r.done_res)
    else $error("ack error without done");

  a_rd_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.read_data != 16'h0000) |-> out_item_r.done_res)
    else $error("read data outside done");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_en |=> in_valid_r && $stable(in_item_r))
    else $error("held input word lost");

endmodule

@@ sim/i2cra_bus_checker.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: bus tick checker
// Watches the input, result and configuration channels of the core, keeps a
// cycle-free model of the bus sequencer, and compares every result word with
// the tick it predicts, field by field, in order.
// ----------------------------------------------------------------------------
module i2cra_bus_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  i2cra_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  i2cra_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   words_pending
);

  localparam int ReportMax = 10;

  // configuration copy
  logic [6:0]  dev_addr;
  logic [7:0]  ack_limit;

  // sequencer copy
  logic [i2cra_pkg::PhaseW-1:0] phase;
  logic [2:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [2:0]  step;
  logic [7:0]  ack_wait;
  logic [7:0]  reg_hold;
  logic [15:0] data_hold;
  logic        reading;
  logic [15:0] rx_word;

  i2cra_pkg::out_item_t bus_ticks_due[$];
  int          fail_total = 0;

  function automatic logic [7:0] tx_byte(input logic [2:0] s);
    case (s)
      i2cra_pkg::STEP_ADDR:  return {dev_addr, 1'b0};
      i2cra_pkg::STEP_REG:   return reg_hold;
      i2cra_pkg::STEP_THIRD: return reading ? {dev_addr, 1'b1} : data_hold[15:8];
      default:               return data_hold[7:0];
    endcase
  endfunction

  task automatic load_byte(input logic [2:0] s);
    step = s;
    shifter = tx_byte(s);
    bit_cnt = '0;
    phase = i2cra_pkg::PH_TX_LOW;
  endtask

  task automatic advance_bus(input i2cra_pkg::in_item_t w, output i2cra_pkg::out_item_t r);
    r = '0;
    r.scl = 1'b1;
    r.busy_res = 1'b1;
    if (phase == i2cra_pkg::PH_IDLE &&
        (w.cmd == i2cra_pkg::CMD_WRITE || w.cmd == i2cra_pkg::CMD_READ)) begin
      reg_hold = w.reg_addr;
      data_hold = w.write_data;
      reading = (w.cmd == i2cra_pkg::CMD_READ);
      rx_word = '0;
      step = i2cra_pkg::STEP_ADDR;
      bit_cnt = '0;
      ack_wait = '0;
      phase = i2cra_pkg::PH_START_A;
    end
    case (phase)
      i2cra_pkg::PH_START_A: phase = i2cra_pkg::PH_START_B;
      i2cra_pkg::PH_START_B: begin
        r.sda_pull_low = 1'b1;
        load_byte(i2cra_pkg::STEP_ADDR);
      end
      i2cra_pkg::PH_TX_LOW: begin
        r.scl = 1'b0;
        r.sda_pull_low = !shifter[7];
        phase = i2cra_pkg::PH_TX_HIGH;
      end
      i2cra_pkg::PH_TX_HIGH: begin
        r.sda_pull_low = !shifter[7];
        shifter = {shifter[6:0], 1'b0};
        if (bit_cnt >= i2cra_pkg::LAST_BIT) begin
          phase = i2cra_pkg::PH_ACK_LOW;
        end else begin
          bit_cnt++;
          phase = i2cra_pkg::PH_TX_LOW;
        end
      end
      i2cra_pkg::PH_ACK_LOW: begin
        r.scl = 1'b0;
        ack_wait = '0;
        phase = i2cra_pkg::PH_ACK_HIGH;
      end
      i2cra_pkg::PH_ACK_HIGH: begin
        if (!w.sda_in) begin
          if (reading) begin
            if (step == i2cra_pkg::STEP_ADDR) begin
              load_byte(i2cra_pkg::STEP_REG);
            end else if (step == i2cra_pkg::STEP_REG) begin
              step = i2cra_pkg::STEP_THIRD;
              phase = i2cra_pkg::PH_RS_A;
            end else begin
              step = i2cra_pkg::STEP_FOURTH;
              bit_cnt = '0;
              shifter = '0;
              phase = i2cra_pkg::PH_RX_LOW;
            end
          end else if (step >= i2cra_pkg::STEP_FOURTH) begin
            phase = i2cra_pkg::PH_STOP_A;
          end else begin
            load_byte(step + 3'd1);
          end
        end else if (ack_wait >= ack_limit) begin
          phase = i2cra_pkg::PH_ESTOP_A;
        end else begin
          ack_wait++;
        end
      end
      i2cra_pkg::PH_RS_A: begin
        r.scl = 1'b0;
        phase = i2cra_pkg::PH_RS_B;
      end
      i2cra_pkg::PH_RS_B: phase = i2cra_pkg::PH_RS_C;
      i2cra_pkg::PH_RS_C: begin
        r.sda_pull_low = 1'b1;
        load_byte(i2cra_pkg::STEP_THIRD);
      end
      i2cra_pkg::PH_RX_LOW: begin
        r.scl = 1'b0;
        phase = i2cra_pkg::PH_RX_HIGH;
      end
      i2cra_pkg::PH_RX_HIGH: begin
        shifter = {shifter[6:0], w.sda_in};
        if (bit_cnt >= i2cra_pkg::LAST_BIT) begin
          rx_word = {rx_word[7:0], shifter};
          phase = i2cra_pkg::PH_MA_LOW;
        end else begin
          bit_cnt++;
          phase = i2cra_pkg::PH_RX_LOW;
        end
      end
      i2cra_pkg::PH_MA_LOW: begin
        r.scl = 1'b0;
        // ACK after the first byte, NACK after the second
        r.sda_pull_low = (step == i2cra_pkg::STEP_FOURTH);
        phase = i2cra_pkg::PH_MA_HIGH;
      end
      i2cra_pkg::PH_MA_HIGH: begin
        r.sda_pull_low = (step == i2cra_pkg::STEP_FOURTH);
        if (step == i2cra_pkg::STEP_FOURTH) begin
          step = i2cra_pkg::STEP_LAST;
          bit_cnt = '0;
          shifter = '0;
          phase = i2cra_pkg::PH_RX_LOW;
        end else begin
          phase = i2cra_pkg::PH_STOP_A;
        end
      end
      i2cra_pkg::PH_STOP_A: begin
        r.scl = 1'b0;
        r.sda_pull_low = 1'b1;
        phase = i2cra_pkg::PH_STOP_B;
      end
      i2cra_pkg::PH_ESTOP_A: begin
        r.scl = 1'b0;
        r.sda_pull_low = 1'b1;
        phase = i2cra_pkg::PH_ESTOP_B;
      end
      i2cra_pkg::PH_STOP_B: begin
        r.sda_pull_low = 1'b1;
        phase = i2cra_pkg::PH_STOP_C;
      end
      i2cra_pkg::PH_ESTOP_B: begin
        r.sda_pull_low = 1'b1;
        phase = i2cra_pkg::PH_ESTOP_C;
      end
      i2cra_pkg::PH_STOP_C: begin
        r.done_res = 1'b1;
        r.read_data = reading ? rx_word : 16'h0000;
        phase = i2cra_pkg::PH_IDLE;
      end
      i2cra_pkg::PH_ESTOP_C: begin
        r.done_res = 1'b1;
        r.ack_error = 1'b1;
        phase = i2cra_pkg::PH_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        phase = i2cra_pkg::PH_IDLE;
      end
    endcase
  endtask

  always @(posedge clk) begin
    i2cra_pkg::out_item_t want;
    i2cra_pkg::out_item_t got;
    if (!rst_n) begin
      dev_addr = i2cra_pkg::ADDRESS_RESET;
      ack_limit = i2cra_pkg::TIMEOUT_RESET;
      phase = i2cra_pkg::PH_IDLE;
      bit_cnt = '0;
      shifter = '0;
      step = i2cra_pkg::STEP_ADDR;
      ack_wait = '0;
      reg_hold = '0;
      data_hold = '0;
      reading = 1'b0;
      rx_word = '0;
      bus_ticks_due.delete();
    end else begin
      // drain before predicting, so an early word cannot meet its own tick
      if (out_valid && out_ready) begin
        got = out_data;
        if (bus_ticks_due.size() == 0) begin
          if (fail_total < ReportMax)
            $display("unexpected word: scl %0b low %0b busy %0b done %0b err %0b data %h",
                     got.scl, got.sda_pull_low, got.busy_res, got.done_res,
                     got.ack_error, got.read_data);
          fail_total++;
        end else begin
          want = bus_ticks_due.pop_front();
          if (got.scl !== want.scl || got.sda_pull_low !== want.sda_pull_low ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.ack_error !== want.ack_error || got.read_data !== want.read_data) begin
            if (fail_total < ReportMax)
              $display({"word mismatch: expected scl %0b low %0b busy %0b done %0b ",
                        "err %0b data %h, got scl %0b low %0b busy %0b done %0b ",
                        "err %0b data %h"},
                       want.scl, want.sda_pull_low, want.busy_res, want.done_res,
                       want.ack_error, want.read_data,
                       got.scl, got.sda_pull_low, got.busy_res, got.done_res,
                       got.ack_error, got.read_data);
            fail_total++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cra_pkg::CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
          i2cra_pkg::CFG_ACK_TIMEOUT:    ack_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_bus(in_data, want);
        bus_ticks_due.push_back(want);
      end
    end
    mismatches <= fail_total;
    words_pending <= bus_ticks_due.size();
  end

endmodule

@@ sim/i2c_register_access_master_core_test.sv @@
// ----------------------------------------------------------------------------
// I2C register access master core testbench
// Feeds bus ticks with random commands and SDA levels through phases of
// different address, acknowledge timeout and handshake pressure; the bus
// checker predicts every result word and this top gives the verdict.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core_test;

  localparam int CycleLimit = 200000;
  localparam int ResetCycles = 12;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  i2cra_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  i2cra_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int mismatches;
  int words_pending;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int sda_low_pct = 50;

  always #2 clk = ~clk;

  i2c_register_access_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cra_bus_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n)
      out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic i2cra_pkg::in_item_t tick_word(input logic [1:0] cmd,
                                                    input logic [7:0] reg_addr,
                                                    input logic [15:0] write_data,
                                                    input logic sda_in);
    i2cra_pkg::in_item_t w;
    w.cmd = cmd;
    w.reg_addr = reg_addr;
    w.write_data = write_data;
    w.sda_in = sda_in;
    return w;
  endfunction

  function automatic i2cra_pkg::in_item_t random_tick();
    logic [1:0] cmd;
    int pick;
    pick = $urandom_range(99);
    // mostly plain ticks; commands landing mid-transaction get ignored
    if (pick < 6)
      cmd = i2cra_pkg::CMD_WRITE;
    else if (pick < 12)
      cmd = i2cra_pkg::CMD_READ;
    else if (pick < 15)
      cmd = CMD_SPARE;
    else
      cmd = i2cra_pkg::CMD_TICK;
    return tick_word(cmd, 8'($urandom), 16'($urandom),
                     ($urandom_range(99) < sda_low_pct) ? 1'b0 : 1'b1);
  endfunction

  task automatic send_tick(input i2cra_pkg::in_item_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and hold until every predicted word has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] addr_val, input logic [7:0] limit_val,
                           input int low_pct, input int s_idle, input int r_stall,
                           input int count);
    drain();
    write_reg(i2cra_pkg::CFG_DEVICE_ADDRESS, addr_val);
    write_reg(i2cra_pkg::CFG_ACK_TIMEOUT, limit_val);
    write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
    sda_low_pct = low_pct;
    send_idle = s_idle;
    recv_stall = r_stall;
    repeat (count) send_tick(random_tick());
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, spare command, write with instant acks,
    // then read commands that arrive while busy
    send_tick(tick_word(i2cra_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0));
    send_tick(tick_word(CMD_SPARE, 8'hFF, 16'hFFFF, 1'b1));
    send_tick(tick_word(i2cra_pkg::CMD_WRITE, 8'hFF, 16'hFFFF, 1'b0));
    repeat (18) send_tick(tick_word(i2cra_pkg::CMD_READ, 8'h00, 16'h0000, 1'b0));
    send_tick(tick_word(i2cra_pkg::CMD_WRITE, 8'h00, 16'h0000, 1'b1));

    // address with bit 7 set checks the seven-bit mask
    run_phase(8'hAA, 8'd250, 50, 0, 0, 200);
    run_phase(8'h7F, 8'd1, 50, 74, 0, 200);
    run_phase(8'h00, 8'd0, 80, 0, 74, 200);
    // SDA stuck high: every acknowledge runs out the longest wait
    run_phase(8'($urandom), 8'd255, 0, 29, 29, 300);
    run_phase(8'($urandom), 8'($urandom_range(20, 2)), 40, 29, 29, 150);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cra_pkg.sv
rtl/i2cra_seq.sv
rtl/i2c_register_access_master_core.sv
sim/i2cra_bus_checker.sv
sim/i2c_register_access_master_core_test.sv
